// ===== rtl/gap_run_counter_defines.svh =====
// Assertion macros used by the gap run counter checker.
`ifndef GAP_RUN_COUNTER_DEFINES_SVH
`define GAP_RUN_COUNTER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define GRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gap run counter check failed");

// The consequent holds in the cycle after the antecedent.
`define GRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gap run counter check failed");

`endif

// ===== rtl/grc_pkg.sv =====
// Shared types, constants and saturating helpers of the gap run counter.
package grc_pkg;

  localparam int PosBits      = 16;
  localparam int CntBits      = 16;
  localparam int IdxBits      = 6;
  localparam int UsedBits     = 7;
  localparam int TableEntries = 64;

  localparam logic [7:0] GapSymbol = 8'd45;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } grc_op_e;

  typedef struct packed {
    grc_op_e             operation;
    logic [7:0]          symbol;
    logic                last_in_sequence;
    logic [IdxBits-1:0]  read_index;
  } grc_in_t;

  typedef struct packed {
    logic                run_closed;
    logic [PosBits-1:0]  run_start;
    logic [PosBits-1:0]  run_length;
    logic [IdxBits-1:0]  entry_index;
    logic [CntBits-1:0]  entry_count;
    logic                new_entry;
    logic                table_full;
    logic                entry_valid;
    logic [UsedBits-1:0] entries_used;
    logic [CntBits-1:0]  sequences_seen;
  } grc_out_t;

  // Lookup or read request that walks the row of table entries.
  typedef struct packed {
    logic                valid;
    logic                is_read;
    logic [PosBits-1:0]  start;
    logic [PosBits-1:0]  length;
    logic [IdxBits-1:0]  index;
    logic [CntBits-1:0]  count;
    logic                hit;
    logic                new_entry;
    logic [UsedBits-1:0] used;
  } grc_tok_t;

  function automatic logic [PosBits-1:0] pos_inc(input logic [PosBits-1:0] v);
    return (v == {PosBits{1'b1}}) ? v : v + PosBits'(1);
  endfunction

  function automatic logic [CntBits-1:0] cnt_inc(input logic [CntBits-1:0] v);
    return (v == {CntBits{1'b1}}) ? v : v + CntBits'(1);
  endfunction

endpackage

// ===== rtl/grc_cell.sv =====
// One table entry of the gap run counter, passing the request on to its neighbor.
module grc_cell import grc_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  grc_tok_t tok_i,
  output grc_tok_t tok_o
);

  localparam logic [IdxBits-1:0]  MyIdx = IdxBits'(CELL_INDEX);
  localparam logic [UsedBits-1:0] MyPos = UsedBits'(CELL_INDEX);

  logic [PosBits-1:0] start_q, start_d;
  logic [PosBits-1:0] length_q, length_d;
  logic [CntBits-1:0] count_q, count_d;
  grc_tok_t           tok_q, tok_d;
  logic               in_use;
  logic               match;
  logic               free_slot;

  assign in_use    = MyPos < tok_i.used;
  assign match     = in_use && (start_q == tok_i.start) && (length_q == tok_i.length);
  assign free_slot = MyPos == tok_i.used;

  always_comb begin
    tok_d    = tok_i;
    start_d  = start_q;
    length_d = length_q;
    count_d  = count_q;
    if (tok_i.valid) begin
      if (tok_i.is_read) begin
        if ((tok_i.index == MyIdx) && in_use) begin
          tok_d.start  = start_q;
          tok_d.length = length_q;
          tok_d.count  = count_q;
          tok_d.hit    = 1'b1;
        end
      end else if (!tok_i.hit) begin
        if (match) begin
          count_d     = cnt_inc(count_q);
          tok_d.count = cnt_inc(count_q);
          tok_d.index = MyIdx;
          tok_d.hit   = 1'b1;
        end else if (free_slot) begin
          start_d         = tok_i.start;
          length_d        = tok_i.length;
          count_d         = CntBits'(1);
          tok_d.count     = CntBits'(1);
          tok_d.index     = MyIdx;
          tok_d.hit       = 1'b1;
          tok_d.new_entry = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    length_q <= length_d;
    count_q  <= count_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/gap_run_counter.sv =====
// Top level of the gap run counter: run tracking, request launch and result register.
//
// Requests arrive on in_valid_i/in_stall_o/in_req_i. A feed request carries one
// alignment symbol; a read request asks for one stored run entry. Results leave
// on out_valid_o/out_stall_i/out_req_o, one result for every request, in order.
// A feed that closes no run writes its result straight into the output register,
// so such feeds stream at one per cycle while that register is free. A feed that
// closes a run, and every read, sends a lookup through the launch register and
// down the row of TABLE_ENTRIES entry registers, one entry per cycle; the next
// request is taken once its result is in the output register.
// A finished result waits in the output register while the receiver stalls; one
// further request is still taken and its result is held inside until the output
// register frees, with in_stall_o high meanwhile.
// Reset clears the run tracker, the column, the sequence count and the number of
// entries in use. Table contents need no clearing, since only entries in use are
// ever matched or read. TABLE_ENTRIES may range from 1 to 64.
module gap_run_counter import grc_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntries
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  grc_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output grc_out_t out_req_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_e;

  state_e              state_q, state_d;
  logic                in_run_q, in_run_d;
  logic [PosBits-1:0]  cur_start_q, cur_start_d;
  logic [PosBits-1:0]  cur_len_q, cur_len_d;
  logic [PosBits-1:0]  column_q, column_d;
  logic [CntBits-1:0]  seq_cnt_q, seq_cnt_d;
  logic [UsedBits-1:0] used_q, used_d;
  logic                out_valid_q, out_valid_d;
  grc_out_t            out_q, out_d;
  grc_out_t            pend_q, pend_d;
  grc_tok_t            launch_q, launch_d;

  grc_tok_t            chain [TABLE_ENTRIES+1];
  grc_tok_t            tail;

  logic                accept;
  logic                out_free;
  logic                is_read;
  logic                is_gap;
  logic                closes;
  logic                needs_walk;
  logic [PosBits-1:0]  gap_start;
  logic [PosBits-1:0]  gap_len;
  logic [PosBits-1:0]  key_start;
  logic [PosBits-1:0]  key_len;
  logic [CntBits-1:0]  seq_next;
  grc_out_t            res_plain;
  grc_out_t            res_tail;

  assign chain[0] = launch_q;
  assign tail     = chain[TABLE_ENTRIES];

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_entry
    grc_cell #(
      .CELL_INDEX(k)
    ) u_entry (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_read    = in_req_i.operation == OP_READ;
  assign is_gap     = in_req_i.symbol == GapSymbol;
  assign gap_start  = in_run_q ? cur_start_q : column_q;
  assign gap_len    = in_run_q ? pos_inc(cur_len_q) : PosBits'(1);
  assign key_start  = is_gap ? gap_start : cur_start_q;
  assign key_len    = is_gap ? gap_len : cur_len_q;
  assign closes     = is_gap ? in_req_i.last_in_sequence : in_run_q;
  assign needs_walk = is_read || closes;
  assign seq_next   = (!is_read && in_req_i.last_in_sequence) ? cnt_inc(seq_cnt_q)
                                                               : seq_cnt_q;

  always_comb begin
    res_plain                = '0;
    res_plain.entries_used   = used_q;
    res_plain.sequences_seen = seq_next;
  end

  always_comb begin
    res_tail                = '0;
    res_tail.run_closed     = !tail.is_read;
    res_tail.run_start      = tail.start;
    res_tail.run_length     = tail.length;
    res_tail.entry_index    = tail.index;
    res_tail.entry_count    = tail.count;
    res_tail.new_entry      = tail.new_entry;
    res_tail.table_full     = !tail.is_read && !tail.hit;
    res_tail.entry_valid    = tail.is_read && tail.hit;
    res_tail.entries_used   = used_q + UsedBits'(tail.new_entry);
    res_tail.sequences_seen = pend_q.sequences_seen;
  end

  always_comb begin
    state_d     = state_q;
    in_run_d    = in_run_q;
    cur_start_d = cur_start_q;
    cur_len_d   = cur_len_q;
    column_d    = column_q;
    seq_cnt_d   = seq_cnt_q;
    used_d      = used_q;
    out_d       = out_q;
    pend_d      = pend_q;
    launch_d    = '0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!is_read) begin
            seq_cnt_d = seq_next;
            if (in_req_i.last_in_sequence) begin
              in_run_d    = 1'b0;
              cur_start_d = '0;
              cur_len_d   = '0;
              column_d    = '0;
            end else begin
              column_d = pos_inc(column_q);
              in_run_d = is_gap;
              if (is_gap) begin
                cur_start_d = gap_start;
                cur_len_d   = gap_len;
              end
            end
          end
          if (needs_walk) begin
            pend_d           = res_plain;
            launch_d.valid   = 1'b1;
            launch_d.is_read = is_read;
            launch_d.start   = is_read ? '0 : key_start;
            launch_d.length  = is_read ? '0 : key_len;
            launch_d.index   = is_read ? in_req_i.read_index : '0;
            launch_d.used    = used_q;
            state_d          = ST_WALK;
          end else if (out_free) begin
            out_d       = res_plain;
            out_valid_d = 1'b1;
          end else begin
            pend_d  = res_plain;
            state_d = ST_HOLD;
          end
        end
      end
      ST_WALK: begin
        if (tail.valid) begin
          used_d = res_tail.entries_used;
          if (out_free) begin
            out_d       = res_tail;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            pend_d  = res_tail;
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_run_q    <= 1'b0;
      cur_start_q <= '0;
      cur_len_q   <= '0;
      column_q    <= '0;
      seq_cnt_q   <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      pend_q      <= '0;
      launch_q    <= '0;
    end else begin
      state_q     <= state_d;
      in_run_q    <= in_run_d;
      cur_start_q <= cur_start_d;
      cur_len_q   <= cur_len_d;
      column_q    <= column_d;
      seq_cnt_q   <= seq_cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      pend_q      <= pend_d;
      launch_q    <= launch_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/grc_checker.sv =====
// Port-level checks of the gap run counter and their binding to the top level.
`include "gap_run_counter_defines.svh"

module grc_checker import grc_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntries
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input grc_in_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input grc_out_t out_req_o
);

  `GRC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_req_o))

  `GRC_ASSERT_NEXT(a_read_busy, in_valid_i && !in_stall_o && (in_req_i.operation == OP_READ), in_stall_o)

  `GRC_ASSERT_NOW(a_new_entry, out_valid_o && out_req_o.new_entry, out_req_o.run_closed && !out_req_o.table_full && (out_req_o.entry_count == CntBits'(1)))

  `GRC_ASSERT_NOW(a_full_drop, out_valid_o && out_req_o.table_full, (out_req_o.entries_used == UsedBits'(TABLE_ENTRIES)) && (out_req_o.entry_count == '0))

  `GRC_ASSERT_NOW(a_read_in_use, out_valid_o && out_req_o.entry_valid, UsedBits'(out_req_o.entry_index) < out_req_o.entries_used)

endmodule

bind gap_run_counter grc_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_grc_checker (.*);
